### rtl/rsa_pkg.sv
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int HEAP_SIZE     = 4096;
  localparam int SLOT_W        = $clog2(HEAP_SIZE);
  localparam int CAP_W         = SLOT_W + 1;
  localparam int PENDING_DEPTH = 256;
  localparam int PEND_AW       = $clog2(PENDING_DEPTH);
  localparam int PEND_CW       = PEND_AW + 1;
  localparam int REGION_COUNT  = 9;
  localparam int REGION_W      = 4;
  localparam int SHADER_REGIONS = 7;
  localparam int SHADER_W      = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int SETTLE_CYCLES = SHADER_REGIONS;
  localparam int SETTLE_W      = 3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_DEFER = 2'd1;
  localparam logic [1:0] OP_APPLY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_PEND_FULL = 2'd2;
  localparam logic [1:0] ST_DROPPED   = 2'd3;

  localparam logic [1:0] KIND_SHADER = 2'd0;
  localparam logic [1:0] KIND_RT     = 2'd1;
  localparam logic [1:0] KIND_DS     = 2'd2;

  localparam logic [REGION_W-1:0] REGION_RT = 4'd7;
  localparam logic [REGION_W-1:0] REGION_DS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_KIND = 3'd0;

endpackage

### rtl/region_slot_allocator.sv
`timescale 1ns / 1ps

// Slot allocator for one heap split into up to nine regions, each with a bump
// counter and a FIFO of freed slots kept in a 4096-word single-port-style RAM
// (one synchronous read, one write). Deferred frees sit in a 256-word pending
// RAM until an apply drains it. One word is worked on at a time and every word
// gives exactly one result. The OUTPUT state loads the result register straight
// after EXEC for a bump allocation or a refused one, a defer or an unknown op; a
// FIFO allocation first passes POP_WAIT for the RAM read, and an apply loops
// through APPLY_RD and APPLY_EX once per pending entry. The next word is taken
// back in IDLE, and the load waits while the previous result is still held on
// the output. If a region layout change left a FIFO head at or beyond twice the
// new capacity, the head is first reduced by a bit-serial remainder unit. Region
// start offsets are a registered prefix sum of the capacities, so after each
// configuration write the input holds off while they settle.
module region_slot_allocator
  import rsa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,   // region[3:0], slot_index[15:4]
  input  logic [1:0]           s_axis_tuser_i,   // opcode[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [15:0]          m_axis_tdata_o,   // allocated_index[11:0], zero pad
  output logic [1:0]           m_axis_tuser_o    // status[1:0]
);

  typedef enum logic [2:0] {
    IDLE, EXEC, POP_WAIT, MODRED, APPLY_RD, APPLY_EX, OUTPUT
  } state_e;

  state_e state_q, mod_ret_q;

  // configuration and layout
  logic [1:0]        heap_kind_q;
  logic [CAP_W-1:0]  size_q    [SHADER_REGIONS];
  logic [CAP_W-1:0]  capc      [SHADER_REGIONS];
  logic [SLOT_W-1:0] start_tab_q [SHADER_REGIONS];
  logic [SETTLE_W-1:0] settle_q;

  // per-region counters
  logic [CAP_W-1:0]  bump_q [REGION_COUNT];
  logic [SLOT_W-1:0] head_q [REGION_COUNT];
  logic [CAP_W-1:0]  fill_q [REGION_COUNT];
  logic [PEND_CW-1:0] pfill_q;

  // request and result
  logic [1:0]          req_op_q;
  logic [REGION_W-1:0] req_region_q;
  logic [SLOT_W-1:0]   req_slot_q;
  logic [SLOT_W-1:0]   res_idx_q;
  logic [1:0]          res_status_q;
  logic [PEND_CW-1:0]  aidx_q;
  logic                drop_q;

  // head remainder unit
  logic [SLOT_W-1:0] mod_head_q;
  logic [CAP_W-1:0]  mod_cap_q;
  logic [CAP_W-1:0]  mod_rem_q;
  logic [3:0]        mod_cnt_q;
  logic [CAP_W-1:0]  mod_t, mod_step;
  logic [CAP_W-1:0]  hm_q;
  logic              hm_ok_q;

  // memories
  logic [SLOT_W-1:0] fs_mem [HEAP_SIZE];
  logic [SLOT_W-1:0] fs_rdata_q;
  logic              fs_we, fs_re;
  logic [SLOT_W-1:0] fs_waddr, fs_raddr;
  logic [SLOT_W+REGION_W-1:0] pd_mem [PENDING_DEPTH];
  logic [SLOT_W+REGION_W-1:0] pd_rdata_q;
  logic              pd_we, pd_re;

  // current region view
  logic [REGION_W-1:0] cur_r;
  logic                r_ok;
  logic [CAP_W-1:0]    cap;
  logic [SLOT_W-1:0]   start;
  logic [SLOT_W-1:0]   head;
  logic [CAP_W-1:0]    fill, bump;
  logic [CAP_W-1:0]    head_ext, head_sub, hm_fast, hm, hm_inc, new_head, pos, posm;
  logic                need_mod, active, pop_go, push_go, accept;

  always_comb begin
    for (int i = 0; i < SHADER_REGIONS; i++) begin
      capc[i] = (size_q[i] > CAP_W'(HEAP_SIZE)) ? CAP_W'(HEAP_SIZE) : size_q[i];
    end
  end

  always_comb begin
    cur_r = (state_q == APPLY_EX) ? pd_rdata_q[REGION_W-1:0] : req_region_q;
    r_ok  = (cur_r < REGION_W'(REGION_COUNT));
    cap   = '0;
    start = '0;
    case (heap_kind_q)
      KIND_SHADER: begin
        if (cur_r < REGION_W'(SHADER_REGIONS)) begin
          cap   = capc[cur_r[SHADER_W-1:0]];
          start = start_tab_q[cur_r[SHADER_W-1:0]];
        end
      end
      KIND_RT: begin
        if (cur_r == REGION_RT) cap = capc[0];
      end
      KIND_DS: begin
        if (cur_r == REGION_DS) cap = capc[0];
      end
      default: cap = '0;
    endcase
    head = r_ok ? head_q[cur_r] : '0;
    fill = r_ok ? fill_q[cur_r] : '0;
    bump = r_ok ? bump_q[cur_r] : '0;

    head_ext = {1'b0, head};
    head_sub = head_ext - cap;
    hm_fast  = (head_ext < cap) ? head_ext : head_sub;
    need_mod = !hm_ok_q && (head_ext >= cap) && (head_sub >= cap);
    hm       = hm_ok_q ? hm_q : hm_fast;
    hm_inc   = hm + CAP_W'(1);
    new_head = (hm_inc == cap) ? '0 : hm_inc;
    pos      = hm + fill;
    posm     = (pos >= cap) ? pos - cap : pos;
    active   = r_ok && (cap != '0);

    pop_go  = (state_q == EXEC) && (req_op_q == OP_ALLOC) && active &&
              (fill != '0) && !need_mod;
    push_go = (state_q == APPLY_EX) && active && (fill < cap) && !need_mod;

    fs_re    = pop_go;
    fs_raddr = start + hm[SLOT_W-1:0];
    fs_we    = push_go;
    fs_waddr = start + posm[SLOT_W-1:0];
    pd_we    = (state_q == EXEC) && (req_op_q == OP_DEFER) &&
               (pfill_q != PEND_CW'(PENDING_DEPTH));
    pd_re    = (state_q == APPLY_RD) && (aidx_q != pfill_q);

    mod_t    = {mod_rem_q[SLOT_W-1:0], mod_head_q[mod_cnt_q]};
    mod_step = (mod_t >= mod_cap_q) ? mod_t - mod_cap_q : mod_t;
  end

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == IDLE) && (settle_q == '0);

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_waddr] <= pd_rdata_q[SLOT_W+REGION_W-1:REGION_W];
    if (fs_re) fs_rdata_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pd_we) pd_mem[pfill_q[PEND_AW-1:0]] <= {req_slot_q, req_region_q};
    if (pd_re) pd_rdata_q <= pd_mem[aidx_q[PEND_AW-1:0]];
  end

  // configuration registers and the registered start prefix sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_kind_q <= KIND_SHADER;
      settle_q    <= '0;
      for (int i = 0; i < SHADER_REGIONS; i++) begin
        size_q[i]      <= '0;
        start_tab_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE_CYCLES);
        if (cfg_idx_i == CFG_HEAP_KIND) begin
          heap_kind_q <= cfg_wdata_i[1:0];
        end else begin
          size_q[cfg_idx_i - CFG_IDX_W'(1)] <= cfg_wdata_i;
        end
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
      start_tab_q[0] <= '0;
      for (int i = 1; i < SHADER_REGIONS; i++) begin
        start_tab_q[i] <= start_tab_q[i-1] + capc[i-1][SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= IDLE;
      mod_ret_q       <= EXEC;
      pfill_q         <= '0;
      hm_ok_q         <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        bump_q[i] <= '0;
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      // OUTPUT reloads the word itself
      if (m_axis_tvalid_o && m_axis_tready_i && (state_q != OUTPUT)) begin
        m_axis_tvalid_o <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            req_op_q     <= s_axis_tuser_i;
            req_region_q <= s_axis_tdata_i[REGION_W-1:0];
            req_slot_q   <= s_axis_tdata_i[REGION_W+SLOT_W-1:REGION_W];
            hm_ok_q      <= 1'b0;
            state_q      <= EXEC;
          end
        end
        EXEC: begin
          res_idx_q    <= '0;
          res_status_q <= ST_OK;
          hm_ok_q      <= 1'b0;
          state_q      <= OUTPUT;
          case (req_op_q)
            OP_ALLOC: begin
              if (!active) begin
                res_status_q <= ST_EXHAUSTED;
              end else if (fill != '0) begin
                if (need_mod) begin
                  mod_head_q <= head;
                  mod_cap_q  <= cap;
                  mod_rem_q  <= '0;
                  mod_cnt_q  <= 4'(SLOT_W - 1);
                  mod_ret_q  <= EXEC;
                  state_q    <= MODRED;
                end else begin
                  head_q[cur_r] <= new_head[SLOT_W-1:0];
                  fill_q[cur_r] <= fill - CAP_W'(1);
                  state_q       <= POP_WAIT;
                end
              end else if (bump < cap) begin
                res_idx_q     <= start + bump[SLOT_W-1:0];
                bump_q[cur_r] <= bump + CAP_W'(1);
              end else begin
                res_status_q <= ST_EXHAUSTED;
              end
            end
            OP_DEFER: begin
              if (pd_we) pfill_q <= pfill_q + PEND_CW'(1);
              else       res_status_q <= ST_PEND_FULL;
            end
            OP_APPLY: begin
              aidx_q  <= '0;
              drop_q  <= 1'b0;
              state_q <= APPLY_RD;
            end
            default: res_status_q <= ST_OK;
          endcase
        end
        POP_WAIT: begin
          res_idx_q <= fs_rdata_q;
          state_q   <= OUTPUT;
        end
        MODRED: begin
          mod_rem_q <= mod_step;
          mod_cnt_q <= mod_cnt_q - 4'd1;
          if (mod_cnt_q == 4'd0) begin
            hm_q    <= mod_step;
            hm_ok_q <= 1'b1;
            state_q <= mod_ret_q;
          end
        end
        APPLY_RD: begin
          if (pd_re) begin
            aidx_q  <= aidx_q + PEND_CW'(1);
            state_q <= APPLY_EX;
          end else begin
            res_idx_q    <= '0;
            res_status_q <= drop_q ? ST_DROPPED : ST_OK;
            pfill_q      <= '0;
            state_q      <= OUTPUT;
          end
        end
        APPLY_EX: begin
          hm_ok_q <= 1'b0;
          state_q <= APPLY_RD;
          if (!active || fill >= cap) begin
            drop_q <= 1'b1;
          end else if (need_mod) begin
            mod_head_q <= head;
            mod_cap_q  <= cap;
            mod_rem_q  <= '0;
            mod_cnt_q  <= 4'(SLOT_W - 1);
            mod_ret_q  <= APPLY_EX;
            state_q    <= MODRED;
          end else begin
            fill_q[cur_r] <= fill + CAP_W'(1);
          end
        end
        OUTPUT: begin
          if (!m_axis_tvalid_o || m_axis_tready_i) begin
            m_axis_tvalid_o <= 1'b1;
            m_axis_tdata_o  <= {{(16 - SLOT_W){1'b0}}, res_idx_q};
            m_axis_tuser_o  <= res_status_q;
            state_q         <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule

### tb/slot_grant_checker.sv
`timescale 1ns / 1ps

module slot_grant_checker
  import rsa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  input  logic                     s_axis_tready_i,
  input  logic [15:0]              s_axis_tdata_i,   // region[3:0], slot_index[15:4]
  input  logic [1:0]               s_axis_tuser_i,   // opcode[1:0]
  input  logic                     m_axis_tvalid_i,
  input  logic                     m_axis_tready_i,
  input  logic [15:0]              m_axis_tdata_i,   // allocated_index[11:0], zero pad
  input  logic [1:0]               m_axis_tuser_i,   // status[1:0]
  output int                       errors_o,
  output int                       outstanding_o,
  output logic [REGION_COUNT-1:0]  queued_mask_o
);

  typedef struct packed {
    logic [SLOT_W-1:0] index;
    logic [1:0]        status;
  } grant_t;

  grant_t expected_grants[$];
  int     mismatches = 0;

  // shadow of the allocator state
  logic [1:0]          kind_q;
  logic [CAP_W-1:0]    size_q       [SHADER_REGIONS];
  logic [CAP_W-1:0]    bump_q       [REGION_COUNT];
  logic [SLOT_W-1:0]   head_q       [REGION_COUNT];
  logic [CAP_W-1:0]    fill_q       [REGION_COUNT];
  logic [SLOT_W-1:0]   store_q      [HEAP_SIZE];
  logic [REGION_W-1:0] pend_region_q[PENDING_DEPTH];
  logic [SLOT_W-1:0]   pend_slot_q  [PENDING_DEPTH];
  int                  pend_cnt;

  assign errors_o = mismatches;

  function automatic int clip_cap(input logic [CAP_W-1:0] v);
    return (v > HEAP_SIZE) ? HEAP_SIZE : int'(v);
  endfunction

  function automatic void region_span(input int r, output int base, output int cap);
    base = 0;
    cap  = 0;
    case (kind_q)
      KIND_SHADER: begin
        if (r < SHADER_REGIONS) begin
          for (int i = 0; i < r; i++) base += clip_cap(size_q[i]);
          cap = clip_cap(size_q[r]);
        end
      end
      KIND_RT: if (r == REGION_RT) cap = clip_cap(size_q[0]);
      KIND_DS: if (r == REGION_DS) cap = clip_cap(size_q[0]);
      default: ;
    endcase
  endfunction

  task automatic predict_grant(input logic [1:0] op, input logic [REGION_W-1:0] rg,
                               input logic [SLOT_W-1:0] slot, output grant_t g);
    int base;
    int cap;
    int r;
    g.index  = '0;
    g.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        region_span(rg, base, cap);
        if (rg >= REGION_COUNT || cap == 0) begin
          g.status = ST_EXHAUSTED;
        end else if (fill_q[rg] != 0) begin
          g.index    = store_q[(base + head_q[rg] % cap) % HEAP_SIZE];
          head_q[rg] = SLOT_W'((head_q[rg] % cap + 1) % cap);
          fill_q[rg] = fill_q[rg] - 1'b1;
        end else if (bump_q[rg] < cap) begin
          g.index    = SLOT_W'(base + bump_q[rg]);
          bump_q[rg] = bump_q[rg] + 1'b1;
        end else begin
          g.status = ST_EXHAUSTED;
        end
      end
      OP_DEFER: begin
        if (pend_cnt >= PENDING_DEPTH) begin
          g.status = ST_PEND_FULL;
        end else begin
          pend_region_q[pend_cnt] = rg;
          pend_slot_q[pend_cnt]   = slot;
          pend_cnt++;
        end
      end
      OP_APPLY: begin
        for (int i = 0; i < pend_cnt; i++) begin
          r = pend_region_q[i];
          region_span(r, base, cap);
          if (r >= REGION_COUNT || cap == 0 || fill_q[r] >= cap) begin
            g.status = ST_DROPPED;
          end else begin
            store_q[(base + (head_q[r] + fill_q[r]) % cap) % HEAP_SIZE] = pend_slot_q[i];
            fill_q[r] = fill_q[r] + 1'b1;
          end
        end
        pend_cnt = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t                  want;
    logic [REGION_COUNT-1:0] mask_v;
    if (!rst_ni) begin
      kind_q   = KIND_SHADER;
      pend_cnt = 0;
      foreach (size_q[i]) size_q[i] = '0;
      for (int r = 0; r < REGION_COUNT; r++) begin
        bump_q[r] = '0;
        head_q[r] = '0;
        fill_q[r] = '0;
      end
      expected_grants.delete();
      outstanding_o <= 0;
      queued_mask_o <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_KIND) kind_q = cfg_wdata_i[1:0];
        else size_q[cfg_idx_i - 1'b1] = cfg_wdata_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_grant(s_axis_tuser_i, s_axis_tdata_i[REGION_W-1:0],
                      s_axis_tdata_i[REGION_W +: SLOT_W], want);
        expected_grants = {expected_grants, want};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_grants.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, index %0d status %0d", $time,
                   m_axis_tdata_i[SLOT_W-1:0], m_axis_tuser_i);
        end else begin
          want = expected_grants.pop_front();
          // pad bits above the index must read zero
          if (m_axis_tdata_i !== 16'(want.index)) begin
            mismatches++;
            $display("%0t: allocated_index expected %0d got %0d (tdata %h)", $time,
                     want.index, m_axis_tdata_i[SLOT_W-1:0], m_axis_tdata_i);
          end
          if (m_axis_tuser_i !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tuser_i);
          end
        end
      end
      for (int r = 0; r < REGION_COUNT; r++) mask_v[r] = (fill_q[r] != 0);
      queued_mask_o <= mask_v;
      outstanding_o <= expected_grants.size();
    end
  end

endmodule

### tb/tb_region_slot_allocator.sv
`timescale 1ns / 1ps

module tb_region_slot_allocator;
  import rsa_pkg::*;

  localparam logic [1:0]           OP_NONE         = 2'd3;
  localparam logic [1:0]           KIND_NONE       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0      = 3'd1;
  localparam int                   ITEMS_PER_PHASE = 40;
  localparam int                   FLOOD_WORDS     = PENDING_DEPTH + 2;
  localparam int                   STALL_LIMIT     = 20000;
  localparam int                   END_SETTLE      = 20;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx   = '0;
  logic [CAP_W-1:0]         cfg_wdata = '0;
  logic                     s_valid   = 1'b0;
  logic [15:0]              s_data    = '0;
  logic [1:0]               s_user    = '0;
  logic                     m_ready   = 1'b0;
  logic                     s_axis_tready_o;
  logic                     m_axis_tvalid_o;
  logic [15:0]              m_axis_tdata_o;
  logic [1:0]               m_axis_tuser_o;

  int                       check_errors;
  int                       outstanding;
  logic [REGION_COUNT-1:0]  queued_mask;

  bit                       gaps_on = 1'b1;
  int                       rx_hold = 0;
  int                       quiet_cycles = 0;

  // stimulus view of the current layout
  logic [CAP_W-1:0]         size_cfg   [SHADER_REGIONS];
  int                       region_base[REGION_COUNT];
  int                       region_cap [REGION_COUNT];
  int                       live_regions[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  region_slot_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  slot_grant_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .errors_o        (check_errors),
    .outstanding_o   (outstanding),
    .queued_mask_o   (queued_mask)
  );

  // result side: when gaps are on, a random stall after every accepted word
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    int stall;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_hold <= 0;
    end else if (m_axis_tvalid_o && m_ready) begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      rx_hold <= stall;
      m_ready <= (stall == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_ready <= (rx_hold == 1);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clip_cap(input logic [CAP_W-1:0] v);
    return (v > HEAP_SIZE) ? HEAP_SIZE : int'(v);
  endfunction

  function automatic logic [REGION_W-1:0] pick_region();
    if (live_regions.size() == 0 || $urandom_range(0, 9) == 0)
      return REGION_W'($urandom_range(0, 15));
    return REGION_W'(live_regions[$urandom_range(0, live_regions.size() - 1)]);
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(input logic [REGION_W-1:0] rg);
    if (rg < REGION_COUNT && region_cap[rg] != 0 && $urandom_range(0, 4) != 0)
      return SLOT_W'((region_base[rg] + $urandom_range(0, region_cap[rg] - 1)) % HEAP_SIZE);
    return SLOT_W'($urandom_range(0, HEAP_SIZE - 1));
  endfunction

  function automatic logic [CAP_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CAP_W'($urandom_range(0, 6));
    if (roll < 85) return CAP_W'($urandom_range(0, HEAP_SIZE));
    return CAP_W'($urandom_range(0, (1 << CAP_W) - 1));
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [REGION_W-1:0] rg,
                           input logic [SLOT_W-1:0] slot);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {slot, rg};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic stop_input();
    s_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic program_layout(input logic [1:0] kind);
    int base;
    cfg_write(CFG_HEAP_KIND, CAP_W'(kind));
    for (int i = 0; i < SHADER_REGIONS; i++)
      cfg_write(CFG_IDX_W'(CFG_SIZE_0 + i), size_cfg[i]);
    cfg_we <= 1'b0;
    base = 0;
    for (int r = 0; r < REGION_COUNT; r++) begin
      region_base[r] = 0;
      region_cap[r]  = 0;
    end
    case (kind)
      KIND_SHADER: begin
        for (int r = 0; r < SHADER_REGIONS; r++) begin
          region_base[r] = base;
          region_cap[r]  = clip_cap(size_cfg[r]);
          base += region_cap[r];
        end
      end
      KIND_RT: region_cap[REGION_RT] = clip_cap(size_cfg[0]);
      KIND_DS: region_cap[REGION_DS] = clip_cap(size_cfg[0]);
      default: ;
    endcase
    live_regions.delete();
    for (int r = 0; r < REGION_COUNT; r++)
      if (region_cap[r] != 0) live_regions = {live_regions, r};
  endtask

  // Push everything pending into the FIFOs and pop them empty, so a layout
  // change never leaves a FIFO pointing at store words it never wrote.
  task automatic flush_frees();
    int r;
    stop_input();
    wait_drained();
    send_word(OP_APPLY, '0, '0);
    stop_input();
    wait_drained();
    while (queued_mask != '0) begin
      r = 0;
      while (!queued_mask[r]) r++;
      send_word(OP_ALLOC, REGION_W'(r), '0);
      stop_input();
      wait_drained();
    end
  endtask

  task automatic random_word();
    int                  roll;
    logic [REGION_W-1:0] rg;
    roll = $urandom_range(0, 99);
    rg   = pick_region();
    if (roll < 40)
      send_word(OP_ALLOC, rg, SLOT_W'($urandom_range(0, HEAP_SIZE - 1)));
    else if (roll < 80)
      send_word(OP_DEFER, rg, pick_slot(rg));
    else if (roll < 92)
      send_word(OP_APPLY, REGION_W'($urandom_range(0, 15)), SLOT_W'($urandom_range(0, 4095)));
    else
      send_word(2'($urandom_range(0, 3)), REGION_W'($urandom_range(0, 15)),
                SLOT_W'($urandom_range(0, HEAP_SIZE - 1)));
  endtask

  initial begin : stimulus
    logic [1:0] kind;
    int         roll;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // regions 0..6 = 2,1,0,1,1,1,1 -> bases 0,2,3,3,4,5,6
    foreach (size_cfg[i]) size_cfg[i] = CAP_W'(1);
    size_cfg[0] = CAP_W'(2);
    size_cfg[2] = '0;
    program_layout(KIND_SHADER);
    send_word(OP_ALLOC, 4'd0, 12'd0);
    send_word(OP_ALLOC, 4'd0, 12'hfff);
    send_word(OP_ALLOC, 4'd0, 12'd0);       // bump counter at capacity
    send_word(OP_ALLOC, 4'd2, 12'd0);       // zero capacity
    send_word(OP_ALLOC, REGION_RT, 12'd0);  // not in this heap kind
    send_word(OP_ALLOC, 4'd15, 12'd0);      // no such region
    send_word(OP_ALLOC, 4'd6, 12'd0);
    send_word(OP_DEFER, 4'd0, 12'd1);
    send_word(OP_DEFER, 4'd0, 12'd0);
    send_word(OP_DEFER, 4'd0, 12'hfff);     // outside region, and overflows its FIFO
    send_word(OP_DEFER, 4'd2, 12'd5);
    send_word(OP_DEFER, REGION_DS, 12'habc);
    send_word(OP_DEFER, 4'd9, 12'h543);
    send_word(OP_NONE, 4'hf, 12'hfff);
    send_word(OP_APPLY, 4'd0, 12'd0);
    send_word(OP_ALLOC, 4'd0, 12'd0);       // oldest free first
    send_word(OP_ALLOC, 4'd0, 12'd0);
    send_word(OP_ALLOC, 4'd0, 12'd0);
    send_word(OP_APPLY, 4'd0, 12'd0);       // nothing pending
    send_word(OP_DEFER, 4'd1, 12'd2);
    send_word(OP_APPLY, 4'd0, 12'd0);
    send_word(OP_ALLOC, 4'd1, 12'd0);       // FIFO wins over bump
    send_word(OP_ALLOC, 4'd1, 12'd0);
    flush_frees();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          foreach (size_cfg[i]) size_cfg[i] = CAP_W'(2);
          kind = KIND_SHADER;
        end
        1: begin
          foreach (size_cfg[i]) size_cfg[i] = '0;
          size_cfg[0] = '1;
          kind = KIND_RT;
        end
        2: begin
          foreach (size_cfg[i]) size_cfg[i] = '1;
          size_cfg[0] = CAP_W'(3);
          kind = KIND_DS;
        end
        3: begin
          foreach (size_cfg[i]) size_cfg[i] = pick_size();
          kind = KIND_NONE;
        end
        4: begin
          foreach (size_cfg[i]) size_cfg[i] = CAP_W'(HEAP_SIZE);
          kind = KIND_SHADER;
        end
        5: begin
          foreach (size_cfg[i]) size_cfg[i] = '1;
          kind = KIND_SHADER;
        end
        default: begin
          foreach (size_cfg[i]) size_cfg[i] = pick_size();
          roll = $urandom_range(0, 9);
          kind = (roll < 6) ? KIND_SHADER : (roll < 8) ? KIND_RT :
                 (roll < 9) ? KIND_DS : KIND_NONE;
        end
      endcase
      program_layout(kind);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        // overrun the pending buffer, then drain it in one apply
        gaps_on = 1'b0;
        for (int n = 0; n < FLOOD_WORDS; n++) begin
          roll = int'(pick_region());
          send_word(OP_DEFER, REGION_W'(roll), pick_slot(REGION_W'(roll)));
        end
        send_word(OP_APPLY, '0, '0);
        gaps_on = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_word();
      flush_frees();
    end

    repeat (END_SETTLE) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### region_slot_allocator.f
rtl/rsa_pkg.sv
rtl/region_slot_allocator.sv
tb/slot_grant_checker.sv
tb/tb_region_slot_allocator.sv
